@@ rtl/led_triangle_heading_defines.svh @@
// ----------------------------------------------------------------------------
// led_triangle_heading_defines.svh
// Assertion macros shared by the LED triangle heading RTL.
// ----------------------------------------------------------------------------
`ifndef LED_TRIANGLE_HEADING_DEFINES_SVH
`define LED_TRIANGLE_HEADING_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LTH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LTH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lth_pkg.sv @@
// ----------------------------------------------------------------------------
// lth_pkg
// Constants, CORDIC angle table and flag types for the LED triangle heading.
// ----------------------------------------------------------------------------
package lth_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int DEG_SHIFT    = 20;   // angle unit inside CORDIC: 2^-20 degree
	localparam int PRE_SHIFT    = 24;   // operand prescale
	localparam int ZW           = 30;   // angle accumulator width

	typedef logic signed [ZW-1:0] zang_t;

	localparam zang_t Z_90  = ZW'(90 * (2**DEG_SHIFT));
	localparam zang_t Z_180 = ZW'(180 * (2**DEG_SHIFT));

	typedef struct packed {
		logic ok;
		logic mirror;
	} turn_flag_t;

	typedef struct packed {
		logic ok;
		logic straight;
	} gam_flag_t;

	typedef struct packed {
		logic zero;
		logic c_pos;
	} cor_spec_t;

	// round(atan(2^-i) in degrees * 2^20)
	function automatic zang_t atan_step(input logic [4:0] i);
		case (i)
			5'd0:    return ZW'(47185920);
			5'd1:    return ZW'(27855475);
			5'd2:    return ZW'(14718068);
			5'd3:    return ZW'(7471121);
			5'd4:    return ZW'(3750058);
			5'd5:    return ZW'(1876857);
			5'd6:    return ZW'(938658);
			5'd7:    return ZW'(469357);
			5'd8:    return ZW'(234682);
			5'd9:    return ZW'(117342);
			5'd10:   return ZW'(58671);
			5'd11:   return ZW'(29335);
			5'd12:   return ZW'(14668);
			5'd13:   return ZW'(7334);
			5'd14:   return ZW'(3667);
			5'd15:   return ZW'(1833);
			5'd16:   return ZW'(917);
			5'd17:   return ZW'(458);
			5'd18:   return ZW'(229);
			5'd19:   return ZW'(115);
			5'd20:   return ZW'(57);
			5'd21:   return ZW'(29);
			5'd22:   return ZW'(14);
			5'd23:   return ZW'(7);
			default: return '0;
		endcase
	endfunction

endpackage

@@ rtl/lth_front.sv @@
// ----------------------------------------------------------------------------
// lth_front
// Five-stage front end: centroid (divide by three), validity flags and the
// cross / dot products that feed the two angle units.
// ----------------------------------------------------------------------------
module lth_front #(
	parameter int W = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [W-1:0]       red_x,
	input  logic signed [W-1:0]       red_y,
	input  logic signed [W-1:0]       green_x,
	input  logic signed [W-1:0]       green_y,
	input  logic signed [W-1:0]       blue_x,
	input  logic signed [W-1:0]       blue_y,
	output logic                      v_out,
	output logic signed [W-1:0]       cx_out,
	output logic signed [W-1:0]       cy_out,
	output lth_pkg::turn_flag_t       tflag_out,
	output lth_pkg::gam_flag_t        gflag_out,
	output logic signed [2*W+2:0]     t_s_out,
	output logic signed [2*W+2:0]     t_c_out,
	output logic signed [2*W+2:0]     g_s_out,
	output logic signed [2*W+2:0]     g_c_out
);
	import lth_pkg::*;

	localparam int SW = W + 2;       // sum of three
	localparam int DW = W + 1;       // differences
	localparam int N  = W + 1;       // magnitude of sum
	localparam int K  = N + 1;       // reciprocal shift
	localparam int PW = 2*W + 1;     // turn products
	localparam int QW = 2*W + 2;     // gamma products
	localparam int IW = 2*W + 3;     // angle operands
	localparam logic [K-1:0] DIV3_M = K'(((2**K) + 2) / 3);

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: sums, differences, raw flags
	logic signed [SW-1:0] sum_x_s1, sum_y_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic signed [W-1:0]  bx_s1, by_s1;
	logic                 allneg_s1, gbad_s1, hid_s1, byok_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_x_s1  <= SW'(red_x) + SW'(green_x) + SW'(blue_x);
			sum_y_s1  <= SW'(red_y) + SW'(green_y) + SW'(blue_y);
			ux_s1     <= DW'(red_x) - DW'(blue_x);
			uy_s1     <= DW'(red_y) - DW'(blue_y);
			vx_s1     <= DW'(green_x) - DW'(blue_x);
			vy_s1     <= DW'(green_y) - DW'(blue_y);
			bx_s1     <= blue_x;
			by_s1     <= blue_y;
			allneg_s1 <= (red_x <= 0) && (green_x <= 0) && (blue_x <= 0);
			gbad_s1   <= red_x[W-1] | red_y[W-1] | green_x[W-1] | green_y[W-1];
			hid_s1    <= blue_x[W-1];
			byok_s1   <= !blue_y[W-1];
		end
	end

	// stage 2: |sum| / 3 by reciprocal multiply, gamma validity
	logic [SW-1:0]  abs_x, abs_y;
	logic [N+K-1:0] prod_x, prod_y;

	always_comb begin
		abs_x  = sum_x_s1[SW-1] ? SW'(-sum_x_s1) : SW'(sum_x_s1);
		abs_y  = sum_y_s1[SW-1] ? SW'(-sum_y_s1) : SW'(sum_y_s1);
		prod_x = (N+K)'(abs_x[N-1:0]) * (N+K)'(DIV3_M);
		prod_y = (N+K)'(abs_y[N-1:0]) * (N+K)'(DIV3_M);
	end

	logic [W-1:0]         qx_s2, qy_s2;
	logic                 negx_s2, negy_s2, allneg_s2;
	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [W-1:0]  bx_s2, by_s2;
	gam_flag_t            gflag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s2     <= prod_x[K +: W];
			qy_s2     <= prod_y[K +: W];
			negx_s2   <= sum_x_s1[SW-1];
			negy_s2   <= sum_y_s1[SW-1];
			allneg_s2 <= allneg_s1;
			ux_s2     <= ux_s1;
			uy_s2     <= uy_s1;
			vx_s2     <= vx_s1;
			vy_s2     <= vy_s1;
			bx_s2     <= bx_s1;
			by_s2     <= by_s1;
			gflag_s2.straight <= hid_s1;
			gflag_s2.ok <= !gbad_s1 && (hid_s1 ? byok_s1 :
				(!(ux_s1 == '0 && uy_s1 == '0) && !(vx_s1 == '0 && vy_s1 == '0)));
		end
	end

	// stage 3: signed centroid
	logic signed [W-1:0] cx_v, cy_v;

	always_comb begin
		cx_v = negx_s2 ? W'(-$signed({1'b0, qx_s2})) : W'($signed({1'b0, qx_s2}));
		cy_v = negy_s2 ? W'(-$signed({1'b0, qy_s2})) : W'($signed({1'b0, qy_s2}));
		if (allneg_s2) begin
			cx_v = '1;
			cy_v = '1;
		end
	end

	logic signed [W-1:0]  cx_s3, cy_s3, bx_s3, by_s3;
	logic                 allneg_s3;
	logic signed [DW-1:0] ux_s3, uy_s3, vx_s3, vy_s3;
	gam_flag_t            gflag_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3     <= cx_v;
			cy_s3     <= cy_v;
			bx_s3     <= bx_s2;
			by_s3     <= by_s2;
			allneg_s3 <= allneg_s2;
			ux_s3     <= ux_s2;
			uy_s3     <= uy_s2;
			vx_s3     <= vx_s2;
			vy_s3     <= vy_s2;
			gflag_s3  <= gflag_s2;
		end
	end

	// stage 4: products
	logic signed [DW-1:0] ax, ay;
	logic signed [PW-1:0] tp1, tp2;
	logic signed [QW-1:0] gp1, gp2, gd1, gd2;

	always_comb begin
		ax  = DW'(cx_s3) - DW'(bx_s3);
		ay  = DW'(cy_s3) - DW'(by_s3);
		tp1 = ax * cy_s3;
		tp2 = ay * cy_s3;
		gp1 = ux_s3 * vy_s3;
		gp2 = uy_s3 * vx_s3;
		gd1 = ux_s3 * vx_s3;
		gd2 = uy_s3 * vy_s3;
	end

	logic signed [W-1:0]  cx_s4, cy_s4;
	logic signed [PW-1:0] tp1_s4, tp2_s4;
	logic signed [QW-1:0] gp1_s4, gp2_s4, gd1_s4, gd2_s4;
	turn_flag_t           tflag_s4;
	gam_flag_t            gflag_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s4  <= cx_s3;
			cy_s4  <= cy_s3;
			tp1_s4 <= tp1;
			tp2_s4 <= tp2;
			gp1_s4 <= gp1;
			gp2_s4 <= gp2;
			gd1_s4 <= gd1;
			gd2_s4 <= gd2;
			tflag_s4.ok     <= !allneg_s3 && !(ax == '0 && ay == '0) && (cy_s3 != '0);
			tflag_s4.mirror <= cx_s3 < bx_s3;
			gflag_s4 <= gflag_s3;
		end
	end

	// stage 5: sine / cosine terms
	logic signed [IW-1:0] gcross;

	assign gcross = IW'(gp1_s4) - IW'(gp2_s4);

	logic signed [W-1:0]  cx_s5, cy_s5;
	logic signed [IW-1:0] t_s_s5, t_c_s5, g_s_s5, g_c_s5;
	turn_flag_t           tflag_s5;
	gam_flag_t            gflag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s5    <= cx_s4;
			cy_s5    <= cy_s4;
			t_s_s5   <= tp1_s4[PW-1] ? -IW'(tp1_s4) : IW'(tp1_s4);
			t_c_s5   <= IW'(tp2_s4);
			g_s_s5   <= gcross[IW-1] ? -gcross : gcross;
			g_c_s5   <= IW'(gd1_s4) + IW'(gd2_s4);
			tflag_s5 <= tflag_s4;
			gflag_s5 <= gflag_s4;
		end
	end

	assign v_out     = v_s5;
	assign cx_out    = cx_s5;
	assign cy_out    = cy_s5;
	assign tflag_out = tflag_s5;
	assign gflag_out = gflag_s5;
	assign t_s_out   = t_s_s5;
	assign t_c_out   = t_c_s5;
	assign g_s_out   = g_s_s5;
	assign g_c_out   = g_c_s5;

endmodule

@@ rtl/lth_cordic.sv @@
// ----------------------------------------------------------------------------
// lth_cordic
// Unrolled vectoring CORDIC: atan2(s, c) for s >= 0, one iteration per
// stage, then clamp and round to 2^-AF degree. Sideband tag rides along.
// ----------------------------------------------------------------------------
module lth_cordic #(
	parameter int IW    = 27,
	parameter int AF    = 6,
	parameter int TAG_W = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic signed [IW-1:0]  s,
	input  logic signed [IW-1:0]  c,
	input  logic [TAG_W-1:0]      tag_in,
	output logic                  out_v,
	output logic [AF+7:0]         angle,
	output logic [TAG_W-1:0]      tag_out
);
	import lth_pkg::*;

	localparam int XW = IW + PRE_SHIFT + 2;
	localparam zang_t HALF = ZW'(2**(DEG_SHIFT - 1 - AF));

	logic signed [XW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XW-1:0] y_s [0:CORDIC_STEPS];
	zang_t                z_s [0:CORDIC_STEPS];
	cor_spec_t            sp_s [0:CORDIC_STEPS];
	logic [TAG_W-1:0]     tag_s [0:CORDIC_STEPS];
	logic                 v_s [0:CORDIC_STEPS];

	// pre-rotation into the right half plane
	logic signed [XW-1:0] xc, xs;

	assign xc = XW'(c) <<< PRE_SHIFT;
	assign xs = XW'(s) <<< PRE_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (c[IW-1]) begin
				x_s[0] <= xs;
				y_s[0] <= -xc;
				z_s[0] <= Z_90;
			end else begin
				x_s[0] <= xc;
				y_s[0] <= xs;
				z_s[0] <= '0;
			end
			sp_s[0].zero  <= (s == '0);
			sp_s[0].c_pos <= (c > 0);
			tag_s[0]      <= tag_in;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		logic signed [XW-1:0] xsh, ysh;
		logic                 ypos;

		assign xsh  = x_s[i] >>> i;
		assign ysh  = y_s[i] >>> i;
		assign ypos = !y_s[i][XW-1] && (y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (ypos) begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + atan_step(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - atan_step(5'(i));
				end
				sp_s[i+1]  <= sp_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	// clamp to [0, 180] degrees, round half up
	zang_t z_sel, z_clip, z_rnd;

	always_comb begin
		if (sp_s[CORDIC_STEPS].zero) begin
			z_sel = sp_s[CORDIC_STEPS].c_pos ? '0 : Z_180;
		end else begin
			z_sel = z_s[CORDIC_STEPS];
		end
		if (z_sel < 0) begin
			z_clip = '0;
		end else if (z_sel > Z_180) begin
			z_clip = Z_180;
		end else begin
			z_clip = z_sel;
		end
		z_rnd = z_clip + HALF;
	end

	logic             v_sf;
	logic [AF+7:0]    ang_sf;
	logic [TAG_W-1:0] tag_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= v_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_sf <= z_rnd[DEG_SHIFT-AF +: AF+8];
			tag_sf <= tag_s[CORDIC_STEPS];
		end
	end

	assign out_v   = v_sf;
	assign angle   = ang_sf;
	assign tag_out = tag_sf;

endmodule

@@ rtl/led_triangle_heading.sv @@
// ----------------------------------------------------------------------------
// led_triangle_heading
// Centroid, heading and interior angle of a red/green/blue LED triangle.
// ----------------------------------------------------------------------------
// Input channel: six LED coordinates (-1 = not found) with in_valid/in_ready.
// Output channel: centroid, turn angle and interior angle at blue, each angle
// with its own valid flag, with out_valid/out_ready. One result per word.
// Pipeline: 5 front-end stages, one pre-rotation stage, 24 CORDIC iteration
// stages, one rounding stage, then the output register. Throughput: one word
// per cycle while in_ready is high; the two CORDIC pipelines, one iteration
// per stage, set that figure.
// Stall: a result that is not taken stays in the output register and the
// next one lands in a skid register; only when the skid register is full
// does in_ready drop and the whole pipeline hold. Nothing is lost or doubled.
// Reset: all valid bits clear, the pipeline is empty, in_ready is high.
// ----------------------------------------------------------------------------
module led_triangle_heading #(
	parameter int COORD_BITS      = 11,
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS:0]   red_x,
	input  logic signed [COORD_BITS:0]   red_y,
	input  logic signed [COORD_BITS:0]   green_x,
	input  logic signed [COORD_BITS:0]   green_y,
	input  logic signed [COORD_BITS:0]   blue_x,
	input  logic signed [COORD_BITS:0]   blue_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS:0]   center_x,
	output logic signed [COORD_BITS:0]   center_y,
	output logic                         turn_valid,
	output logic [ANGLE_FRAC_BITS+8:0]   turn_angle,
	output logic                         gamma_valid,
	output logic [ANGLE_FRAC_BITS+7:0]   gamma
);
	import lth_pkg::*;

	`include "led_triangle_heading_defines.svh"

	localparam int W     = COORD_BITS + 1;
	localparam int IW    = 2*W + 3;
	localparam int AW    = ANGLE_FRAC_BITS + 8;
	localparam int TW    = ANGLE_FRAC_BITS + 9;
	localparam int TTAG  = 2*W + 2;
	localparam logic [TW-1:0] TURN_FULL = TW'(360 * (2**ANGLE_FRAC_BITS));
	localparam logic [AW-1:0] GAM_HALF  = AW'(180 * (2**ANGLE_FRAC_BITS));

	logic en;
	logic skid_v_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// front end
	logic                 f_v;
	logic signed [W-1:0]  f_cx, f_cy;
	turn_flag_t           f_tflag;
	gam_flag_t            f_gflag;
	logic signed [IW-1:0] f_ts, f_tc, f_gs, f_gc;

	lth_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.red_x     (red_x),
		.red_y     (red_y),
		.green_x   (green_x),
		.green_y   (green_y),
		.blue_x    (blue_x),
		.blue_y    (blue_y),
		.v_out     (f_v),
		.cx_out    (f_cx),
		.cy_out    (f_cy),
		.tflag_out (f_tflag),
		.gflag_out (f_gflag),
		.t_s_out   (f_ts),
		.t_c_out   (f_tc),
		.g_s_out   (f_gs),
		.g_c_out   (f_gc)
	);

	// angle units
	logic            t_v, g_v;
	logic [AW-1:0]   t_ang, g_ang;
	logic [TTAG-1:0] t_tag;
	gam_flag_t       g_tag;

	lth_cordic #(.IW(IW), .AF(ANGLE_FRAC_BITS), .TAG_W(TTAG)) u_cor_turn (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (f_v),
		.s       (f_ts),
		.c       (f_tc),
		.tag_in  ({f_cx, f_cy, f_tflag}),
		.out_v   (t_v),
		.angle   (t_ang),
		.tag_out (t_tag)
	);

	lth_cordic #(.IW(IW), .AF(ANGLE_FRAC_BITS), .TAG_W(2)) u_cor_gam (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (f_v),
		.s       (f_gs),
		.c       (f_gc),
		.tag_in  (f_gflag),
		.out_v   (g_v),
		.angle   (g_ang),
		.tag_out (g_tag)
	);

	// final selection
	turn_flag_t          t_flag;
	logic signed [W-1:0] n_cx, n_cy;
	logic [TW-1:0]       n_turn;
	logic [AW-1:0]       n_gam;

	always_comb begin
		n_cx   = t_tag[TTAG-1 -: W];
		n_cy   = t_tag[2 +: W];
		t_flag = t_tag[1:0];
		if (!t_flag.ok) begin
			n_turn = '0;
		end else if (t_flag.mirror) begin
			n_turn = TURN_FULL - TW'(t_ang);
		end else begin
			n_turn = TW'(t_ang);
		end
		if (!g_tag.ok) begin
			n_gam = '0;
		end else if (g_tag.straight) begin
			n_gam = GAM_HALF;
		end else begin
			n_gam = g_ang;
		end
	end

	// output register and skid register
	logic                out_v_q;
	logic signed [W-1:0] cx_q, cy_q, sk_cx_q, sk_cy_q;
	logic                tv_q, gv_q, sk_tv_q, sk_gv_q;
	logic [TW-1:0]       turn_q, sk_turn_q;
	logic [AW-1:0]       gam_q, sk_gam_q;
	logic                load_out, load_skid, drain_skid;

	assign load_out   = en && (!out_v_q || out_ready);
	assign load_skid  = en && out_v_q && !out_ready && t_v;
	assign drain_skid = skid_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= t_v;
			end else if (drain_skid) begin
				out_v_q <= 1'b1;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (drain_skid) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cx_q   <= n_cx;
			cy_q   <= n_cy;
			tv_q   <= t_flag.ok;
			turn_q <= n_turn;
			gv_q   <= g_tag.ok;
			gam_q  <= n_gam;
		end else if (drain_skid) begin
			cx_q   <= sk_cx_q;
			cy_q   <= sk_cy_q;
			tv_q   <= sk_tv_q;
			turn_q <= sk_turn_q;
			gv_q   <= sk_gv_q;
			gam_q  <= sk_gam_q;
		end
		if (load_skid) begin
			sk_cx_q   <= n_cx;
			sk_cy_q   <= n_cy;
			sk_tv_q   <= t_flag.ok;
			sk_turn_q <= n_turn;
			sk_gv_q   <= g_tag.ok;
			sk_gam_q  <= n_gam;
		end
	end

	assign out_valid   = out_v_q;
	assign center_x    = cx_q;
	assign center_y    = cy_q;
	assign turn_valid  = tv_q;
	assign turn_angle  = turn_q;
	assign gamma_valid = gv_q;
	assign gamma       = gam_q;

	// both angle pipelines must stay in step
	`LTH_ASSERT_NOW(a_lockstep, 1'b1, t_v == g_v, "angle pipelines out of step")
	`LTH_ASSERT_NOW(a_skid_out, skid_v_q, out_v_q, "skid word without output word")
	`LTH_ASSERT_NEXT(a_skid_hold, skid_v_q && !out_ready, skid_v_q && $stable(sk_gam_q),
		"skid word lost during stall")
	`LTH_ASSERT_NOW(a_gam_range, out_v_q && gv_q, gam_q <= GAM_HALF,
		"interior angle above 180 degrees")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_triangle_heading. A table of directed LED
// triangles (missing LEDs, extremes, degenerate and straight angles) is sent
// first, then random triangles and raw words. Each result is checked against a
// local centroid/CORDIC prediction, or a typed-in one for fixed rows. Both sides
// throttle at random, with a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 11;
	localparam int AF = 6;
	localparam int N_RANDOM = 1880;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;

	typedef logic signed [CB:0] coord_t;

	typedef struct packed {
		coord_t            cx;
		coord_t            cy;
		logic              tv;
		logic [AF+8:0]     ta;
		logic              gv;
		logic [AF+7:0]     ga;
	} heading_t;

	typedef struct packed {
		coord_t   rx, ry, gx, gy, bx, by;
		logic     fixed;
		heading_t res;
	} triangle_row_t;

	// atan(2^-i) in degrees, 2^-20 units
	localparam longint ATAN_DEG [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t red_x = '0, red_y = '0, green_x = '0, green_y = '0, blue_x = '0, blue_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t center_x, center_y;
	logic turn_valid, gamma_valid;
	logic [AF+8:0] turn_angle;
	logic [AF+7:0] gamma;

	heading_t      heading_q[$];
	triangle_row_t directed_rows[$];
	int            mismatches = 0;
	bit            hold_req = 1'b0;
	bit            hold_done = 1'b0;

	// directed rows carrying a typed-in result
	bit dut_row_fixed = 1'b0;
	heading_t fixed_res = '0;

	always #2 clk = ~clk;

	led_triangle_heading dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_x(red_x), .red_y(red_y), .green_x(green_x), .green_y(green_y),
		.blue_x(blue_x), .blue_y(blue_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.center_x(center_x), .center_y(center_y),
		.turn_valid(turn_valid), .turn_angle(turn_angle),
		.gamma_valid(gamma_valid), .gamma(gamma)
	);

	// atan2(s, c), s >= 0, in 2^-AF degree
	function automatic longint arc_deg(input longint s, input longint c);
		longint x, y, z, t, nx, ny;
		int i;
		if (s == 0) begin
			z = (c > 0) ? 0 : (longint'(180) << 20);
		end else begin
			x = c * (longint'(1) << 24);
			y = s * (longint'(1) << 24);
			z = 0;
			if (x < 0) begin
				t = x;
				x = y;
				y = -t;
				z = longint'(90) << 20;
			end
			for (i = 0; i < 24; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z += ATAN_DEG[i];
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z -= ATAN_DEG[i];
				end
				x = nx;
				y = ny;
			end
		end
		if (z < 0) z = 0;
		if (z > (longint'(180) << 20)) z = longint'(180) << 20;
		z += longint'(1) << (20 - 1 - AF);
		return z >>> (20 - AF);
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic heading_t heading_of(input coord_t rxi, ryi, gxi, gyi, bxi, byi);
		longint rx, ry, gx, gy, bx, by, cx, cy, ax, ay, a, ux, uy, vx, vy;
		heading_t h;
		rx = rxi; ry = ryi; gx = gxi; gy = gyi; bx = bxi; by = byi;
		h = '0;
		if (rx <= 0 && gx <= 0 && bx <= 0) begin
			cx = -1;
			cy = -1;
		end else begin
			cx = (rx + gx + bx) / 3;
			cy = (ry + gy + by) / 3;
			ax = cx - bx;
			ay = cy - by;
			if (!(ax == 0 && ay == 0) && cy != 0) begin
				a = arc_deg(mag(ax * cy), ay * cy);
				if (cx < bx) a = (longint'(360) << AF) - a;
				h.ta = a[AF+8:0];
				h.tv = 1'b1;
			end
		end
		h.cx = cx[CB:0];
		h.cy = cy[CB:0];
		if (rx < 0 || ry < 0 || gx < 0 || gy < 0) begin
			h.gv = 1'b0;
		end else if (bx < 0) begin
			if (by >= 0) begin
				h.ga = (AF+8)'(180 << AF);
				h.gv = 1'b1;
			end
		end else begin
			ux = rx - bx; uy = ry - by;
			vx = gx - bx; vy = gy - by;
			if (!(ux == 0 && uy == 0) && !(vx == 0 && vy == 0)) begin
				a = arc_deg(mag(ux * vy - uy * vx), ux * vx + uy * vy);
				h.ga = a[AF+7:0];
				h.gv = 1'b1;
			end
		end
		return h;
	endfunction

	task automatic add_row(input coord_t rx, ry, gx, gy, bx, by, input bit fixed,
			input heading_t res);
		directed_rows.push_back({rx, ry, gx, gy, bx, by, fixed, res});
	endtask

	// offer one word and hold it until taken
	task automatic offer(input coord_t rx, ry, gx, gy, bx, by);
		@(negedge clk);
		red_x <= rx; red_y <= ry; green_x <= gx; green_y <= gy;
		blue_x <= bx; blue_y <= by;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic sender_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (heading_q.size() != 0) @(posedge clk);
	endtask

	function automatic coord_t pick_coord(input int mode);
		if (mode == 0) return coord_t'($urandom);
		if ($urandom_range(0, 11) == 0) return -1;
		return coord_t'($urandom_range(0, 2047));
	endfunction

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		heading_t got, want;
		if (arst_n && in_valid && in_ready && !dut_row_fixed)
			heading_q.push_back(heading_of(red_x, red_y, green_x, green_y, blue_x, blue_y));
		else if (arst_n && in_valid && in_ready)
			heading_q.push_back(fixed_res);
		if (arst_n && out_valid && out_ready) begin
			got = {center_x, center_y, turn_valid, turn_angle, gamma_valid, gamma};
			if (heading_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %p", got);
			end else begin
				want = heading_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		int phase;
		bit busy;
		phase = 0;
		busy = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
				out_ready <= 1'b1;
			end else begin
				if (phase == 0) begin
					busy = ($urandom_range(0, 2) == 0);
					phase = busy ? $urandom_range(1, 8) : $urandom_range(1, 40);
				end
				phase--;
				out_ready <= !busy;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		triangle_row_t r;
		int k, mode;
		coord_t rx, ry, gx, gy, bx, by;

		// all missing
		add_row(-1, -1, -1, -1, -1, -1, 1, {-12'sd1, -12'sd1, 1'b0, 15'd0, 1'b0, 14'd0});
		// all at origin: no x seen, blue on red
		add_row(0, 0, 0, 0, 0, 0, 1, {-12'sd1, -12'sd1, 1'b0, 15'd0, 1'b0, 14'd0});
		// all at max: centroid on blue, blue on red
		add_row(2047, 2047, 2047, 2047, 2047, 2047, 1,
			{12'sd2047, 12'sd2047, 1'b0, 15'd0, 1'b0, 14'd0});
		// blue between red and green: straight angle, centroid on blue
		add_row(0, 10, 20, 10, 10, 10, 1, {12'sd10, 12'sd10, 1'b0, 15'd0, 1'b1, 14'd11520});
		// heading straight up the axis, zero interior angle
		add_row(10, 20, 10, 20, 10, -10, 1, {12'sd10, 12'sd10, 1'b1, 15'd0, 1'b1, 14'd0});
		// centroid on row zero
		add_row(3, 0, 6, 0, 9, 0, 1, {12'sd6, 12'sd0, 1'b0, 15'd0, 1'b1, 14'd0});
		// blue x hidden, y seen
		add_row(10, 10, 20, 20, -1, 5, 0, '0);
		// blue fully hidden
		add_row(10, 10, 20, 20, -1, -1, 0, '0);
		// red or green missing
		add_row(-1, 300, 500, 600, 700, 100, 0, '0);
		add_row(100, 300, 500, -1, 700, 100, 0, '0);
		// blue on green
		add_row(100, 900, 400, 400, 400, 400, 0, '0);
		// most negative and mixed extremes
		add_row(-2048, -2048, -2048, -2048, -2048, -2048, 0, '0);
		add_row(2047, -2048, -2048, 2047, 2047, 2047, 0, '0);
		add_row(-2048, 2047, 2047, -2048, -2048, 0, 0, '0);
		add_row(2047, 0, 0, 2047, 0, 0, 0, '0);
		// mirror side and plain triangles
		add_row(100, 100, 200, 120, 900, 800, 0, '0);
		add_row(900, 100, 800, 120, 100, 800, 0, '0);
		add_row(1000, 1000, 1010, 1000, 1005, 1001, 0, '0);
		add_row(5, 2000, 2040, 7, 1, 1, 0, '0);
		add_row(0, 1, 0, 2, 0, 3, 0, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// flags change right after an accept, before the next word is offered
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			dut_row_fixed <= r.fixed;
			fixed_res <= r.res;
			offer(r.rx, r.ry, r.gx, r.gy, r.bx, r.by);
			sender_gap();
		end
		dut_row_fixed <= 1'b0;

		for (k = 0; k < N_RANDOM; k++) begin
			if (k == 400) hold_req = 1'b1;
			if (k == 900) wait_drained();
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				rx = pick_coord(1); ry = pick_coord(1);
				gx = pick_coord(1); gy = pick_coord(1);
				bx = pick_coord(1); by = pick_coord(1);
			end else if (mode < 8) begin
				// small triangle around one point
				rx = coord_t'($urandom_range(8, 2039));
				ry = coord_t'($urandom_range(8, 2039));
				gx = rx + coord_t'($urandom_range(0, 16)) - 8;
				gy = ry + coord_t'($urandom_range(0, 16)) - 8;
				bx = rx + coord_t'($urandom_range(0, 16)) - 8;
				by = ry + coord_t'($urandom_range(0, 16)) - 8;
				if ($urandom_range(0, 5) == 0) begin
					bx = gx;
					by = gy;
				end
			end else begin
				rx = pick_coord(0); ry = pick_coord(0);
				gx = pick_coord(0); gy = pick_coord(0);
				bx = pick_coord(0); by = pick_coord(0);
			end
			offer(rx, ry, gx, gy, bx, by);
			if (!(hold_req && !hold_done)) sender_gap();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (heading_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ led_triangle_heading.f @@
+incdir+rtl
rtl/lth_pkg.sv
rtl/lth_front.sv
rtl/lth_cordic.sv
rtl/led_triangle_heading.sv
tb/testbench.sv
